### sv/rlde_pkg.sv
// Shared types, constants and helper functions of the run-length decimal encoder.
`default_nettype none

package rlde_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 17;
	localparam int POS_W      = 16;
	localparam int NDIG_W     = 3;
	localparam int WEIGHT_W   = 20;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

	// One input transaction
	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              in_last;
	} in_item_t;

	// One output transaction
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [POS_W-1:0]  out_position;
		logic              out_last;
	} out_item_t;

	// A closed run handed from the front to the back end
	typedef struct packed {
		logic [BYTE_W-1:0] run_byte;
		logic [LEN_W-1:0]  run_length;
		logic [NDIG_W-1:0] num_digits;
		logic              is_final;
		logic              has_extra;
		logic [BYTE_W-1:0] extra_byte;
	} run_rec_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_status_t;

	typedef enum logic [1:0] {
		PH_BYTE,
		PH_DIGIT,
		PH_EXTRA
	} phase_t;

	// c * 10^k, c in 1..9, k in 0..5
	function automatic logic [WEIGHT_W-1:0] digit_weight(input logic [NDIG_W-1:0] k,
		input logic [3:0] c);
		logic [WEIGHT_W-1:0] pow;
		logic [WEIGHT_W+3:0] prod;
		case (k)
			3'd0: pow = 20'd1;
			3'd1: pow = 20'd10;
			3'd2: pow = 20'd100;
			3'd3: pow = 20'd1000;
			3'd4: pow = 20'd10000;
			3'd5: pow = 20'd100000;
			default: pow = 20'd0;
		endcase
		prod = {4'b0, pow} * {20'b0, c};
		return prod[WEIGHT_W-1:0];
	endfunction

	// Number of decimal digits emitted for a run; zero for a single byte
	function automatic logic [NDIG_W-1:0] count_digits(input logic [LEN_W-1:0] len);
		logic [WEIGHT_W-1:0] x;
		logic [NDIG_W-1:0] n;
		x = WEIGHT_W'(len);
		if (x < 20'd2)
			n = 3'd0;
		else if (x < 20'd10)
			n = 3'd1;
		else if (x < 20'd100)
			n = 3'd2;
		else if (x < 20'd1000)
			n = 3'd3;
		else if (x < 20'd10000)
			n = 3'd4;
		else if (x < 20'd100000)
			n = 3'd5;
		else
			n = 3'd6;
		return n;
	endfunction

endpackage

`default_nettype wire

### sv/rlde_if.sv
// Valid/ready stream interfaces for the encoder's input and output channels.
`default_nettype none

interface rlde_in_if;
	logic               valid;
	logic               ready;
	rlde_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rlde_out_if;
	logic                valid;
	logic                ready;
	rlde_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/rlde_front.sv
// Front end: tracks the open run and queues a record each time a run closes.
`default_nettype none

module rlde_front #(
	parameter int MAX_RUN = 65536
) (
	input  wire                         clk,
	input  wire                         arst_n,
	rlde_in_if.sink                     raw,
	input  wire rlde_pkg::fifo_status_t status,
	output logic                        push,
	output rlde_pkg::run_rec_t          rec
);

	localparam logic [rlde_pkg::LEN_W-1:0] MaxRunL = rlde_pkg::LEN_W'(MAX_RUN);

	logic [rlde_pkg::BYTE_W-1:0] run_byte_q;
	logic [rlde_pkg::LEN_W-1:0]  run_length_q;
	logic                        run_open_q;
	logic                        accept;
	logic                        cont;
	logic [rlde_pkg::LEN_W-1:0]  len_inc;

	assign raw.ready = !status.full;
	assign accept    = raw.valid && raw.ready;
	assign cont      = run_open_q && (raw.data.in_byte == run_byte_q) &&
		(run_length_q < MaxRunL);
	assign len_inc   = run_length_q + 1'b1;

	// Record for the run that this transaction closes
	always_comb begin
		push           = 1'b0;
		rec.run_byte   = run_byte_q;
		rec.run_length = run_length_q;
		rec.is_final   = 1'b0;
		rec.has_extra  = 1'b0;
		rec.extra_byte = raw.data.in_byte;
		if (accept) begin
			if (raw.data.in_last) begin
				push         = 1'b1;
				rec.is_final = 1'b1;
				if (cont) begin
					rec.run_length = len_inc;
				end else if (run_open_q) begin
					rec.has_extra = 1'b1;
				end else begin
					rec.run_byte   = raw.data.in_byte;
					rec.run_length = rlde_pkg::LEN_W'(1);
				end
			end else if (!cont && run_open_q) begin
				push = 1'b1;
			end
		end
		rec.num_digits = rlde_pkg::count_digits(rec.run_length);
	end

	// Open run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_byte_q   <= '0;
			run_length_q <= '0;
			run_open_q   <= 1'b0;
		end else if (accept) begin
			if (raw.data.in_last) begin
				run_byte_q   <= '0;
				run_length_q <= '0;
				run_open_q   <= 1'b0;
			end else if (cont) begin
				run_length_q <= len_inc;
			end else begin
				run_byte_q   <= raw.data.in_byte;
				run_length_q <= rlde_pkg::LEN_W'(1);
				run_open_q   <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_length_q <= MaxRunL)
		else $error("run length beyond limit");
`endif

endmodule

`default_nettype wire

### sv/rlde_fifo.sv
// Short queue of closed-run records between the front and back ends.
`default_nettype none

module rlde_fifo (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         push,
	input  wire rlde_pkg::run_rec_t     push_data,
	input  wire                         pop,
	output rlde_pkg::run_rec_t          head,
	output rlde_pkg::fifo_status_t      status
);

	rlde_pkg::run_rec_t           mem_q [rlde_pkg::FIFO_DEPTH];
	logic [rlde_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [rlde_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [rlde_pkg::FIFO_CW-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == rlde_pkg::FIFO_CW'(rlde_pkg::FIFO_DEPTH));

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full || pop)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### sv/rlde_back.sv
// Back end: expands run records into the byte, its decimal digits and any extra byte, one per cycle while enc is ready.
`default_nettype none

module rlde_back #(
	parameter int MAX_STREAM_LEN = 65536
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire rlde_pkg::run_rec_t     head,
	input  wire rlde_pkg::fifo_status_t status,
	output logic                        pop,
	rlde_out_if.source                  enc
);

	localparam logic [rlde_pkg::POS_W-1:0] PosCap = rlde_pkg::POS_W'(MAX_STREAM_LEN - 1);

	logic                          cur_valid_q;
	rlde_pkg::run_rec_t            cur_q;
	rlde_pkg::phase_t              phase_q;
	rlde_pkg::phase_t              phase_d;
	logic [rlde_pkg::NDIG_W-1:0]   digit_idx_q;
	logic [rlde_pkg::LEN_W-1:0]    rem_q;
	logic                          out_valid_q;
	rlde_pkg::out_item_t           out_q;
	logic [rlde_pkg::POS_W-1:0]    pos_q;

	logic [3:0]                    digit;
	logic [rlde_pkg::WEIGHT_W-1:0] sub;
	logic [rlde_pkg::BYTE_W-1:0]   emit_byte;
	logic                          entry_end;
	logic                          emit_last;
	logic                          adv;
	logic                          fire;
	logic                          load_next;

	// Current decimal digit: count of multiples of 10^k that fit
	always_comb begin
		digit = '0;
		sub   = '0;
		for (int c = 1; c <= 9; c++) begin
			if (rlde_pkg::WEIGHT_W'(rem_q) >= rlde_pkg::digit_weight(digit_idx_q, 4'(c))) begin
				digit = 4'(c);
				sub   = rlde_pkg::digit_weight(digit_idx_q, 4'(c));
			end
		end
	end

	// Output of the sequencer
	always_comb begin
		case (phase_q)
			rlde_pkg::PH_BYTE: begin
				emit_byte = cur_q.run_byte;
				entry_end = (cur_q.num_digits == '0) && !cur_q.has_extra;
			end
			rlde_pkg::PH_DIGIT: begin
				emit_byte = rlde_pkg::ASCII_ZERO + {4'b0, digit};
				entry_end = (digit_idx_q == '0) && !cur_q.has_extra;
			end
			rlde_pkg::PH_EXTRA: begin
				emit_byte = cur_q.extra_byte;
				entry_end = 1'b1;
			end
			default: begin
				emit_byte = cur_q.run_byte;
				entry_end = 1'b1;
			end
		endcase
	end

	assign emit_last = cur_q.is_final && entry_end;
	assign adv       = !out_valid_q || enc.ready;
	assign fire      = cur_valid_q && adv;
	assign load_next = !cur_valid_q || (fire && entry_end);
	assign pop       = load_next && !status.empty;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (pop) begin
			phase_d = rlde_pkg::PH_BYTE;
		end else if (fire) begin
			case (phase_q)
				rlde_pkg::PH_BYTE: begin
					if (cur_q.num_digits != '0)
						phase_d = rlde_pkg::PH_DIGIT;
					else if (cur_q.has_extra)
						phase_d = rlde_pkg::PH_EXTRA;
				end
				rlde_pkg::PH_DIGIT: begin
					if (digit_idx_q == '0 && cur_q.has_extra)
						phase_d = rlde_pkg::PH_EXTRA;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q     <= rlde_pkg::PH_BYTE;
		end else begin
			phase_q <= phase_d;
			if (pop)
				cur_valid_q <= 1'b1;
			else if (load_next)
				cur_valid_q <= 1'b0;
		end
	end

	// Current record and digit remainder
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q       <= head;
			rem_q       <= head.run_length;
			digit_idx_q <= head.num_digits - 1'b1;
		end else if (fire && phase_q == rlde_pkg::PH_DIGIT) begin
			rem_q       <= rem_q - sub[rlde_pkg::LEN_W-1:0];
			digit_idx_q <= digit_idx_q - 1'b1;
		end
	end

	// Output register and stream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (fire)
				out_valid_q <= 1'b1;
			else if (enc.ready)
				out_valid_q <= 1'b0;
			if (fire) begin
				if (emit_last)
					pos_q <= '0;
				else if (pos_q < PosCap)
					pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.out_byte     <= emit_byte;
			out_q.out_position <= pos_q;
			out_q.out_last     <= emit_last;
		end
	end

	assign enc.valid = out_valid_q;
	assign enc.data  = out_q;

`ifndef SYNTHESIS
	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit_last) |=> pos_q == '0)
		else $error("position not restarted after last byte");
	a_digit_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == rlde_pkg::PH_DIGIT) |=>
		(out_q.out_byte >= 8'h30 && out_q.out_byte <= 8'h39))
		else $error("digit out of range");
`endif

endmodule

`default_nettype wire

### sv/run_length_decimal_encoder.sv
// Top level of the streaming run-length encoder with decimal run counts.
//
// Channels: raw takes one byte per transaction with in_last on the final byte
// of a stream; enc delivers compressed bytes (run byte, then the run length in
// ASCII decimal, most significant digit first, when the run is longer than one)
// with out_position and out_last on the final compressed byte.
// Throughput: one input transaction per cycle while the run queue is not full;
// the output side delivers one byte per cycle while enc.ready is high. A run
// that continues produces nothing; a closed run yields its byte, digits and any
// extra byte in the back end, the four-entry run queue absorbs that, and
// raw.ready drops only while the queue is full. A closed run's first byte goes
// through the run queue, the current-record and the output register to enc.
// Reset: no run open, position zero, queue and output register empty.
// Stall: when enc.ready is low the output register holds its transaction; the
// back end, then the queue, then raw.ready back up in turn.
`default_nettype none

module run_length_decimal_encoder #(
	parameter int MAX_RUN        = 65536,
	parameter int MAX_STREAM_LEN = 65536
) (
	input  wire         clk,
	input  wire         arst_n,
	rlde_in_if.sink     raw,
	rlde_out_if.source  enc
);

	logic                   push;
	logic                   pop;
	rlde_pkg::run_rec_t     rec;
	rlde_pkg::run_rec_t     head;
	rlde_pkg::fifo_status_t status;

	rlde_front #(
		.MAX_RUN (MAX_RUN)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.status (status),
		.push   (push),
		.rec    (rec)
	);

	rlde_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (rec),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	rlde_back #(
		.MAX_STREAM_LEN (MAX_STREAM_LEN)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.status (status),
		.pop    (pop),
		.enc    (enc)
	);

endmodule

`default_nettype wire

### sim/rlde_checker.sv
// Channel monitor for the run-length encoder: predicts the compressed stream and compares it.
`timescale 1ns / 100ps

module rlde_checker #(
	parameter int MAX_RUN        = 65536,
	parameter int MAX_STREAM_LEN = 65536
) (
	input  wire  clk,
	input  wire  arst_n,
	rlde_in_if   raw,
	rlde_out_if  enc,
	output int   errors,
	output int   pending
);

	localparam int POS_CAP = (MAX_STREAM_LEN - 1 > 65535) ? 65535 : MAX_STREAM_LEN - 1;

	// Predictor state: the open run and the next compressed index
	logic [rlde_pkg::BYTE_W-1:0] cur_byte;
	int                          cur_len;
	bit                          cur_open;
	int                          next_pos;
	int                          fail_count;

	rlde_pkg::out_item_t predicted_bytes[$];

	// Queue one compressed byte at the current index; the index saturates
	task automatic push_byte(input logic [rlde_pkg::BYTE_W-1:0] b, input bit is_last);
		rlde_pkg::out_item_t item;
		item.out_byte     = b;
		item.out_position = next_pos[rlde_pkg::POS_W-1:0];
		item.out_last     = is_last;
		predicted_bytes.push_back(item);
		if (next_pos < POS_CAP)
			next_pos++;
	endtask

	// Run byte, then its length in decimal when the run holds more than one byte
	task automatic close_run(input bit final_run);
		int len;
		int nd;
		int digit_val[6];
		len = cur_len;
		nd  = 0;
		if (len > 1) begin
			while (len > 0) begin
				digit_val[nd] = len % 10;
				nd++;
				len = len / 10;
			end
		end
		push_byte(cur_byte, final_run && nd == 0);
		for (int i = nd - 1; i >= 0; i--)
			push_byte(rlde_pkg::ASCII_ZERO + 8'(digit_val[i]), final_run && i == 0);
	endtask

	// One raw byte: extend the run or close it, then flush on end of stream
	task automatic encode_raw_byte(input rlde_pkg::in_item_t it);
		if (cur_open && it.in_byte == cur_byte && cur_len < MAX_RUN) begin
			cur_len++;
		end else begin
			if (cur_open)
				close_run(1'b0);
			cur_byte = it.in_byte;
			cur_len  = 1;
			cur_open = 1'b1;
		end
		if (it.in_last) begin
			close_run(1'b1);
			cur_open = 1'b0;
			cur_len  = 0;
			cur_byte = '0;
			next_pos = 0;
		end
	endtask

	task automatic field_mismatch(input string field, input logic [15:0] want,
		input logic [15:0] got);
		fail_count++;
		$error("%s: expected %0d, actual %0d", field, want, got);
	endtask

	task automatic check_enc(input rlde_pkg::out_item_t got);
		rlde_pkg::out_item_t want;
		if (predicted_bytes.size() == 0) begin
			fail_count++;
			$error("output with nothing pending: out_byte %0d out_position %0d out_last %0d",
				got.out_byte, got.out_position, got.out_last);
			return;
		end
		want = predicted_bytes.pop_front();
		if (got.out_byte !== want.out_byte)
			field_mismatch("out_byte", 16'(want.out_byte), 16'(got.out_byte));
		if (got.out_position !== want.out_position)
			field_mismatch("out_position", want.out_position, got.out_position);
		if (got.out_last !== want.out_last)
			field_mismatch("out_last", 16'(want.out_last), 16'(got.out_last));
	endtask

	// Sample both channels at the clock edge; counts go out through nonblocking assignments
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_byte   = '0;
			cur_len    = 0;
			cur_open   = 1'b0;
			next_pos   = 0;
			fail_count = 0;
			predicted_bytes.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (raw.valid && raw.ready)
				encode_raw_byte(raw.data);
			if (enc.valid && enc.ready)
				check_enc(enc.data);
			errors  <= fail_count;
			pending <= predicted_bytes.size();
		end
	end

endmodule

### sim/tb_top.sv
// Testbench top for the run-length encoder: clock, reset, stimulus, backpressure and verdict.
`timescale 1ns / 100ps

module tb_top;

	localparam int RUN_LIMIT   = 65536;
	localparam int STREAM_LEN  = 65536;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;

	rlde_in_if  raw_ch ();
	rlde_out_if enc_ch ();

	int chk_errors;
	int chk_pending;

	int src_stall_pct;
	int snk_stall_pct;
	bit hold_req;
	int random_items;
	int quiet_cycles;
	logic [rlde_pkg::BYTE_W-1:0] prev_byte;

	run_length_decimal_encoder #(
		.MAX_RUN        (RUN_LIMIT),
		.MAX_STREAM_LEN (STREAM_LEN)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_ch),
		.enc    (enc_ch)
	);

	rlde_checker #(
		.MAX_RUN        (RUN_LIMIT),
		.MAX_STREAM_LEN (STREAM_LEN)
	) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_ch),
		.enc     (enc_ch),
		.errors  (chk_errors),
		.pending (chk_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one raw byte, possibly after an idle burst; returns at the accepting edge
	task automatic send_raw(input logic [rlde_pkg::BYTE_W-1:0] b, input logic is_last);
		rlde_pkg::in_item_t item;
		item.in_byte = b;
		item.in_last = is_last;
		if (src_stall_pct != 0 && $urandom_range(0, 99) < src_stall_pct) begin
			raw_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		raw_ch.valid <= 1'b1;
		raw_ch.data  <= item;
		do
			@(posedge clk);
		while (!raw_ch.ready);
	endtask

	task automatic send_run(input logic [rlde_pkg::BYTE_W-1:0] b, input int len,
		input logic end_stream);
		for (int k = 0; k < len; k++)
			send_raw(b, end_stream && k == len - 1);
	endtask

	// Stop offering and wait until every predicted byte has come out
	task automatic wait_drained();
		raw_ch.valid <= 1'b0;
		@(posedge clk);
		wait (chk_pending == 0);
		@(posedge clk);
	endtask

	// Stream of runs: mostly short, some medium, a few long; bytes lean on
	// digit characters and repeats of the previous run so runs merge
	task automatic send_random_stream();
		int n_runs;
		int run_len;
		int pick;
		logic [rlde_pkg::BYTE_W-1:0] b;
		n_runs = $urandom_range(1, 8);
		for (int r = 0; r < n_runs; r++) begin
			case ($urandom_range(0, 3))
				0: b = 8'($urandom_range(0, 255));
				1: b = rlde_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
				2: b = prev_byte;
				default: b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 60)
				run_len = $urandom_range(1, 3);
			else if (pick < 92)
				run_len = $urandom_range(4, 12);
			else
				run_len = $urandom_range(13, 30);
			send_run(b, run_len, r == n_runs - 1);
			prev_byte = b;
			random_items += run_len;
		end
	endtask

	// Output side: random stall bursts, plus one long hold-off on request
	initial begin
		enc_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				enc_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req     <= 1'b0;
				enc_ch.ready <= 1'b1;
			end else if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
				enc_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				enc_ch.ready <= 1'b1;
			end else begin
				enc_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (raw_ch.valid && raw_ch.ready) || (enc_ch.valid && enc_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		raw_ch.valid  <= 1'b0;
		raw_ch.data   <= '0;
		src_stall_pct = 0;
		snk_stall_pct = 0;
		random_items  = 0;
		prev_byte     = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-byte streams at both byte extremes, a pair closed by
		// end of stream, a run closed by a new byte that is itself the last
		send_raw(8'h00, 1'b1);
		send_raw(8'hFF, 1'b1);
		send_raw(8'hAA, 1'b0);
		send_raw(8'hAA, 1'b1);
		send_run(8'h55, 3, 1'b0);
		send_raw(8'h56, 1'b1);
		// two-digit count, then digit characters as run bytes
		send_run(8'h41, 10, 1'b1);
		send_raw(8'h30, 1'b0);
		send_raw(8'h31, 1'b0);
		send_raw(8'h31, 1'b0);
		send_raw(8'h30, 1'b1);
		wait_drained();

		// Longer runs: a three-digit count closed by a new last byte (the most
		// results from one transaction here), then digit-count boundaries
		snk_stall_pct = 10;
		send_run(8'h7E, 100, 1'b0);
		send_raw(8'h7F, 1'b1);
		send_run(8'h31, 9, 1'b0);
		send_run(8'h32, 10, 1'b0);
		send_run(8'h33, 11, 1'b1);
		wait_drained();

		// Random streams, idling on both sides
		src_stall_pct = 15;
		snk_stall_pct = 15;
		while (random_items < 30)
			send_random_stream();

		// Output held off while distinct bytes keep coming: the run queue fills
		// and the input stalls
		wait_drained();
		src_stall_pct = 0;
		hold_req <= 1'b1;
		for (int k = 0; k < 40; k++)
			send_raw(8'(k * 37 + 3), k == 39);
		random_items += 40;
		wait_drained();

		// Heavy backpressure, then a bursty sender
		src_stall_pct = 0;
		snk_stall_pct = 35;
		while (random_items < 100)
			send_random_stream();
		src_stall_pct = 35;
		snk_stall_pct = 0;
		while (random_items < 125)
			send_random_stream();

		// Closing stretch with no idling
		src_stall_pct = 0;
		snk_stall_pct = 0;
		while (random_items < 150)
			send_random_stream();

		wait_drained();
		repeat (20) @(posedge clk);
		if (chk_errors == 0 && chk_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
